// ===== hdl/pcir_pkg.sv =====
package pcir_pkg;

   // addresses with special write rules
   localparam logic [7:0] ADDR_CMD_LO   = 8'h04;
   localparam logic [7:0] ADDR_CMD_HI   = 8'h05;
   localparam logic [7:0] ADDR_STAT_HI  = 8'h07;
   localparam logic [7:0] ADDR_ROUTE_LO = 8'h80;
   localparam logic [7:0] ADDR_ROUTE_HI = 8'h81;

   // reset contents of the bytes that have one
   localparam logic [7:0] RST_VENDOR_LO = 8'h25;
   localparam logic [7:0] RST_VENDOR_HI = 8'h10;
   localparam logic [7:0] RST_DEVICE_LO = 8'h35;
   localparam logic [7:0] RST_DEVICE_HI = 8'h14;
   localparam logic [7:0] RST_CMD_LO    = 8'h07;
   localparam logic [7:0] RST_STAT_HI   = 8'h04;
   localparam logic [7:0] RST_CLASS     = 8'h06;
   localparam logic [7:0] RST_ROUTE_LO  = 8'h80;

   // write masks
   localparam logic [7:0] CMD_LO_MASK   = 8'h7f;
   localparam logic [7:0] CMD_LO_FORCE  = 8'h07;
   localparam logic [7:0] CMD_HI_MASK   = 8'h01;
   localparam logic [7:0] STAT_W1C_MASK = 8'hb8;

   localparam logic       CMD_READ      = 1'b0;
   localparam logic       CMD_WRITE     = 1'b1;
   localparam logic [2:0] FUNC_ZERO     = 3'd0;
   localparam logic [7:0] BYTE_ABSENT   = 8'hff;
   localparam logic [7:0] BYTE_ZERO     = 8'h00;

   localparam int NUM_PINS = 4;

   // one configuration beat once it has been taken
   typedef struct packed {
      logic       wr;
      logic [7:0] addr;
      logic [7:0] data;
   } access_type;

   // what the control registers show to the request stage
   typedef struct packed {
      logic [7:0] rd_byte;
      logic       fixed;
      logic [7:0] route_lo;
      logic [7:0] route_hi;
   } ctrl_view_type;

   typedef struct packed {
      logic [NUM_PINS-1:0][3:0] route;
      logic [15:0]              set_mask;
      logic [15:0]              clr_mask;
   } route_result_type;

   function automatic logic [3:0] irq_of(input logic [2:0] sel);
      logic [3:0] irq;
      case (sel)
         3'd0: irq = 4'd0;
         3'd1: irq = 4'd5;
         3'd2: irq = 4'd9;
         3'd3: irq = 4'd10;
         3'd4: irq = 4'd11;
         3'd5: irq = 4'd12;
         3'd6: irq = 4'd14;
         3'd7: irq = 4'd15;
         default: irq = 4'd0;
      endcase
      return irq;
   endfunction

   function automatic logic is_read_only(input logic [7:0] a);
      return (a < 8'h04) || (a == 8'h06) || (a >= 8'h08 && a <= 8'h0b) ||
             (a >= 8'h0f && a < 8'h30) || (a >= 8'h34 && a < 8'h40);
   endfunction

   function automatic logic [7:0] reset_value(input logic [7:0] a);
      logic [7:0] v;
      case (a)
         8'h00: v = RST_VENDOR_LO;
         8'h01: v = RST_VENDOR_HI;
         8'h02: v = RST_DEVICE_LO;
         8'h03: v = RST_DEVICE_HI;
         8'h04: v = RST_CMD_LO;
         8'h07: v = RST_STAT_HI;
         8'h0b: v = RST_CLASS;
         8'h80: v = RST_ROUTE_LO;
         default: v = BYTE_ZERO;
      endcase
      return v;
   endfunction

   function automatic logic is_special(input logic [7:0] a);
      return (a == ADDR_CMD_LO) || (a == ADDR_CMD_HI) || (a == ADDR_STAT_HI) ||
             (a == ADDR_ROUTE_LO) || (a == ADDR_ROUTE_HI);
   endfunction

endpackage

// ===== hdl/pci_config_space_irq_router.sv =====
// configuration space with interrupt routing, one byte access per beat
// start is captured by the request stage, and rsp_strobe and the result
// are registered by the result stage after it
// throughput: one beat every cycle, busy is always low
// reset (synchronous, active high) restores the fixed id/command/status/class
// contents and routing, and drops any beat in flight
// results cannot be stalled; rsp_strobe is high for exactly one cycle per beat
module pci_config_space_irq_router
   import pcir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [2:0]  req_func_num,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_wr_data,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_rd_data,
   output logic [3:0]  rsp_route_a,
   output logic [3:0]  rsp_route_b,
   output logic [3:0]  rsp_route_c,
   output logic [3:0]  rsp_route_d,
   output logic [15:0] rsp_level_set_mask,
   output logic [15:0] rsp_level_clear_mask,
   output logic        rsp_routing_update
);

   logic             accept;
   logic             is_f0;
   access_type       acc;
   ctrl_view_type    view;
   logic [7:0]       mem_byte;
   route_result_type route_res;

   // request stage: writes land here, reads are launched
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_fixed_ff, s1_fixed_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic [7:0] s1_route_lo_ff;
   logic [7:0] s1_route_hi_ff;
   logic       s1_upd_ff, s1_upd_in;

   // result stage
   logic        rsp_strobe_ff;
   logic [7:0]  rsp_rd_data_ff, rsp_rd_data_in;
   logic [3:0]  rsp_route_a_ff, rsp_route_b_ff, rsp_route_c_ff, rsp_route_d_ff;
   logic [15:0] rsp_set_ff, rsp_clr_ff;
   logic        rsp_upd_ff;

   // every cycle can take a beat
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_f0  = (req_func_num == FUNC_ZERO);

   // only function 0 writes touch any storage
   assign acc.wr   = accept && (req_cmd == CMD_WRITE) && is_f0;
   assign acc.addr = req_reg_addr;
   assign acc.data = req_wr_data;

   pcir_ctrl_regs u_ctrl (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .view  (view)
   );

   pcir_bytes u_bytes (
      .clock   (clock),
      .reset   (reset),
      .acc     (acc),
      .rd_byte (mem_byte)
   );

   always_comb begin
      s1_valid_in = accept;
      s1_upd_in   = acc.wr && (req_reg_addr == ADDR_ROUTE_LO ||
                               req_reg_addr == ADDR_ROUTE_HI);
      if (req_cmd == CMD_WRITE) begin
         // writes return zero
         s1_fixed_in = 1'b1;
         s1_byte_in  = BYTE_ZERO;
      end else if (!is_f0) begin
         // absent function floats high
         s1_fixed_in = 1'b1;
         s1_byte_in  = BYTE_ABSENT;
      end else begin
         s1_fixed_in = view.fixed;
         s1_byte_in  = view.rd_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_fixed_ff    <= s1_fixed_in;
      s1_byte_ff     <= s1_byte_in;
      s1_route_lo_ff <= view.route_lo;
      s1_route_hi_ff <= view.route_hi;
      s1_upd_ff      <= s1_upd_in;
   end

   // routing table lookup and edge/level masks from the captured bytes
   pcir_route_calc u_route (
      .route_lo (s1_route_lo_ff),
      .route_hi (s1_route_hi_ff),
      .update   (s1_upd_ff),
      .res      (route_res)
   );

   assign rsp_rd_data_in = s1_fixed_ff ? s1_byte_ff : mem_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
      rsp_rd_data_ff <= rsp_rd_data_in;
      rsp_route_a_ff <= route_res.route[0];
      rsp_route_b_ff <= route_res.route[1];
      rsp_route_c_ff <= route_res.route[2];
      rsp_route_d_ff <= route_res.route[3];
      rsp_set_ff     <= route_res.set_mask;
      rsp_clr_ff     <= route_res.clr_mask;
      rsp_upd_ff     <= s1_upd_ff;
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_rd_data          = rsp_rd_data_ff;
   assign rsp_route_a          = rsp_route_a_ff;
   assign rsp_route_b          = rsp_route_b_ff;
   assign rsp_route_c          = rsp_route_c_ff;
   assign rsp_route_d          = rsp_route_d_ff;
   assign rsp_level_set_mask   = rsp_set_ff;
   assign rsp_level_clear_mask = rsp_clr_ff;
   assign rsp_routing_update   = rsp_upd_ff;

endmodule

// ===== hdl/pcir_bytes.sv =====
module pcir_bytes
   import pcir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  access_type acc,
   output logic [7:0] rd_byte
);

   logic [7:0] mem_ff [256];
   logic [255:0] valid_ff;
   logic [7:0] rd_data_ff;
   logic       rd_valid_ff;
   logic       mem_we;

   // plain bytes only; control and read-only bytes live elsewhere
   assign mem_we = acc.wr && !is_read_only(acc.addr) && !is_special(acc.addr);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[acc.addr] <= acc.data;
      end
      rd_data_ff <= mem_ff[acc.addr];
   end

   // an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[acc.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[acc.addr];
      end
   end

   assign rd_byte = rd_valid_ff ? rd_data_ff : BYTE_ZERO;

endmodule

// ===== hdl/pcir_ctrl_regs.sv =====
module pcir_ctrl_regs
   import pcir_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  access_type    acc,
   output ctrl_view_type view
);

   logic [7:0] cmd_lo_ff, cmd_lo_in;
   logic [7:0] cmd_hi_ff, cmd_hi_in;
   logic [7:0] stat_hi_ff, stat_hi_in;
   logic [7:0] route_lo_ff, route_lo_in;
   logic [7:0] route_hi_ff, route_hi_in;

   always_comb begin
      cmd_lo_in   = cmd_lo_ff;
      cmd_hi_in   = cmd_hi_ff;
      stat_hi_in  = stat_hi_ff;
      route_lo_in = route_lo_ff;
      route_hi_in = route_hi_ff;
      if (acc.wr) begin
         case (acc.addr)
            ADDR_CMD_LO:   cmd_lo_in   = (acc.data & CMD_LO_MASK) | CMD_LO_FORCE;
            ADDR_CMD_HI:   cmd_hi_in   = acc.data & CMD_HI_MASK;
            ADDR_STAT_HI:  stat_hi_in  = stat_hi_ff & ~(acc.data & STAT_W1C_MASK);
            ADDR_ROUTE_LO: route_lo_in = acc.data;
            ADDR_ROUTE_HI: route_hi_in = acc.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_lo_ff   <= RST_CMD_LO;
         cmd_hi_ff   <= BYTE_ZERO;
         stat_hi_ff  <= RST_STAT_HI;
         route_lo_ff <= RST_ROUTE_LO;
         route_hi_ff <= BYTE_ZERO;
      end else begin
         cmd_lo_ff   <= cmd_lo_in;
         cmd_hi_ff   <= cmd_hi_in;
         stat_hi_ff  <= stat_hi_in;
         route_lo_ff <= route_lo_in;
         route_hi_ff <= route_hi_in;
      end
   end

   // read side: current register values or the fixed read-only contents
   always_comb begin
      case (acc.addr)
         ADDR_CMD_LO:   view.rd_byte = cmd_lo_ff;
         ADDR_CMD_HI:   view.rd_byte = cmd_hi_ff;
         ADDR_STAT_HI:  view.rd_byte = stat_hi_ff;
         ADDR_ROUTE_LO: view.rd_byte = route_lo_ff;
         ADDR_ROUTE_HI: view.rd_byte = route_hi_ff;
         default:       view.rd_byte = reset_value(acc.addr);
      endcase
      view.fixed    = is_special(acc.addr) || is_read_only(acc.addr);
      // routing as it stands after this beat
      view.route_lo = route_lo_in;
      view.route_hi = route_hi_in;
   end

endmodule

// ===== hdl/pcir_route_calc.sv =====
module pcir_route_calc
   import pcir_pkg::*;
(
   input  logic             [7:0] route_lo,
   input  logic             [7:0] route_hi,
   input  logic                   update,
   output route_result_type       res
);

   logic [NUM_PINS-1:0][3:0] nib;
   logic [15:0]              set_acc;
   logic [15:0]              clr_acc;
   logic [3:0]               irq;
   logic [15:0]              bit_sel;

   assign nib = {route_hi[7:4], route_hi[3:0], route_lo[7:4], route_lo[3:0]};

   // later pins override earlier ones on the level bit
   always_comb begin
      set_acc = '0;
      clr_acc = '0;
      irq     = '0;
      bit_sel = '0;
      for (int p = 0; p < NUM_PINS; p++) begin
         irq     = irq_of(nib[p][2:0]);
         bit_sel = 16'(1) << irq;
         res.route[p] = irq;
         if (irq != 4'd0) begin
            clr_acc = clr_acc | bit_sel;
            if (nib[p][3]) begin
               set_acc = set_acc | bit_sel;
            end else begin
               set_acc = set_acc & ~bit_sel;
            end
         end
      end
      res.set_mask = update ? set_acc : 16'h0000;
      res.clr_mask = update ? clr_acc : 16'h0000;
   end

endmodule

// ===== hdl/pcir_checker.sv =====
module pcir_checker
   import pcir_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_cmd,
   input logic [2:0]  req_func_num,
   input logic [7:0]  req_reg_addr,
   input logic        rsp_strobe,
   input logic [7:0]  rsp_rd_data,
   input logic [15:0] rsp_level_set_mask,
   input logic [15:0] rsp_level_clear_mask,
   input logic        rsp_routing_update
);

   // every taken beat gives a strobe once it has passed the request and result stages
   a_beat_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted beat produced no result");

   // no strobe without a matching beat taken ahead of it
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted beat");

   // masks only accompany a routing update
   a_masks_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_routing_update) |->
         (rsp_level_set_mask == 16'h0000 && rsp_level_clear_mask == 16'h0000))
      else $error("edge/level masks set without routing update");

   // a function 0 write to a routing byte reports an update
   a_route_write_update: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_WRITE && req_func_num == FUNC_ZERO &&
       (req_reg_addr == ADDR_ROUTE_LO || req_reg_addr == ADDR_ROUTE_HI))
         |=> ##1 rsp_routing_update)
      else $error("routing write not reported");

   // reads of an absent function float high
   a_absent_func: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_READ && req_func_num != FUNC_ZERO)
         |=> ##1 (rsp_rd_data == BYTE_ABSENT))
      else $error("absent function read not 0xff");

endmodule

bind pci_config_space_irq_router pcir_checker u_pcir_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_cmd              (req_cmd),
   .req_func_num         (req_func_num),
   .req_reg_addr         (req_reg_addr),
   .rsp_strobe           (rsp_strobe),
   .rsp_rd_data          (rsp_rd_data),
   .rsp_level_set_mask   (rsp_level_set_mask),
   .rsp_level_clear_mask (rsp_level_clear_mask),
   .rsp_routing_update   (rsp_routing_update)
);
